// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define UDFF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("udff assertion failed");

// condition must never be seen at a clock edge outside reset
`define UDFF_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("udff forbidden condition seen");

`else

`define UDFF_ASSERT(lbl, clk, rst, prop)
`define UDFF_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== design/udff_pkg.sv =====
// ---------------------------------------------------------------------------
// udff_pkg
// types and constants shared by the unsigned decimal field formatter
// ---------------------------------------------------------------------------
package udff_pkg;

   // field limits
   localparam int MAX_FIELD  = 63;
   localparam int FIELD_W    = $clog2(MAX_FIELD + 1);

   // payload widths
   localparam int VALUE_W    = 32;
   localparam int WIDTH_IN_W = 6;
   localparam int PREC_IN_W  = 7;
   localparam int CHAR_W     = 8;

   // bcd digit chain
   localparam int BCD_W      = 4;
   localparam int NUM_DIGITS = 10;
   localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
   localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
   localparam int CNT_W      = $clog2(VALUE_W);

   // ascii codes
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

   typedef logic [NUM_DIGITS-1:0][BCD_W-1:0] bcd_row_type;

   // control from the sequencer to the digit chain
   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LAYOUT,
      ST_EMIT
   } udff_state_type;

endpackage

// ===== design/unsigned_decimal_field_formatter.sv =====
// characters follow conversion and layout, one per cycle while rsp_stall is low
// req_stall holds off a new item until the whole field is emitted
// the conversion shifts the value bit-serially through the bcd digit chain
// a new item is taken while the final character still waits at the output
// reset: synchronous, active high; clears sequencer, counter and output valid
// ---------------------------------------------------------------------------
// unsigned_decimal_field_formatter
// printf style %u field formatter, one ascii character per result beat
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module unsigned_decimal_field_formatter
   import udff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic [WIDTH_IN_W-1:0] req_field_width,
   input  logic signed [PREC_IN_W-1:0] req_precision,
   input  logic                  req_bare_dot,
   input  logic                  req_left_justify,
   input  logic                  req_zero_pad,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_character,
   output logic                  rsp_last
);

   udff_state_type   state_ff, state_in;
   chain_ctrl_type   chain_ctrl;
   bcd_row_type      digits;
   logic             chain_done;
   logic             accept;

   // item parameters
   logic [FIELD_W-1:0] width_ff, width_in;
   logic [FIELD_W-1:0] prec_ff, prec_in;
   logic               has_prec_ff, has_prec_in;
   logic               left_ff, zpad_ff;

   // layout
   logic [NDIG_W-1:0]  ndig;
   logic [FIELD_W-1:0] ndig_ext, total, zeros, spaces, lead;
   logic [FIELD_W-1:0] total_ff, lead_ff, zero_end_ff, dig_end_ff;
   logic               digits_ok;

   // emission
   logic [FIELD_W-1:0] pos_ff, pos_in;
   logic [FIELD_W-1:0] dig_sel;
   logic [CHAR_W-1:0]  char_in, char_ff;
   logic               last_in, last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // decode width and precision on the input beat
   always_comb begin
      if (int'(req_field_width) > MAX_FIELD) begin
         width_in = FIELD_W'(MAX_FIELD);
      end else begin
         width_in = FIELD_W'(req_field_width);
      end
      if (req_bare_dot) begin
         has_prec_in = 1'b1;
         prec_in     = '0;
      end else if (req_precision[PREC_IN_W-1]) begin
         has_prec_in = 1'b0;
         prec_in     = '0;
      end else if (int'(req_precision[PREC_IN_W-2:0]) > MAX_FIELD) begin
         has_prec_in = 1'b1;
         prec_in     = FIELD_W'(MAX_FIELD);
      end else begin
         has_prec_in = 1'b1;
         prec_in     = FIELD_W'(req_precision[PREC_IN_W-2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         width_ff    <= width_in;
         prec_ff     <= prec_in;
         has_prec_ff <= has_prec_in;
         left_ff     <= req_left_justify;
         zpad_ff     <= req_zero_pad;
      end
   end

   // digit chain
   assign chain_ctrl.load  = accept;
   assign chain_ctrl.shift = (state_ff == ST_CONVERT);

   udff_digit_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (chain_ctrl),
      .value  (req_value),
      .digits (digits),
      .done   (chain_done)
   );

   // digit count and field layout from the converted digits
   always_comb begin
      ndig      = NDIG_W'(1);
      digits_ok = 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digits[i] != '0) begin
            ndig = NDIG_W'(i + 1);
         end
         if (digits[i] > BCD_W'(9)) begin
            digits_ok = 1'b0;
         end
      end
      // zero value with empty precision prints no digit at all
      if (has_prec_ff && (prec_ff == '0) && (digits == '0)) begin
         ndig = '0;
      end
      ndig_ext = FIELD_W'(ndig);

      total = ndig_ext;
      if (width_ff > total) begin
         total = width_ff;
      end
      if (has_prec_ff && (prec_ff > total)) begin
         total = prec_ff;
      end

      if (zpad_ff && !has_prec_ff) begin
         zeros = total - ndig_ext;
      end else if (has_prec_ff && (prec_ff > ndig_ext)) begin
         zeros = prec_ff - ndig_ext;
      end else begin
         zeros = '0;
      end
      spaces = total - ndig_ext - zeros;
      lead   = left_ff ? '0 : spaces;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LAYOUT) begin
         total_ff    <= total;
         lead_ff     <= lead;
         zero_end_ff <= lead + zeros;
         dig_end_ff  <= lead + zeros + ndig_ext;
      end
   end

   // character at the current position
   always_comb begin
      dig_sel = dig_end_ff - pos_ff - FIELD_W'(1);
      if (pos_ff < lead_ff) begin
         char_in = CH_SPACE;
      end else if (pos_ff < zero_end_ff) begin
         char_in = CH_ZERO;
      end else if (pos_ff < dig_end_ff) begin
         char_in = CH_ZERO + CHAR_W'(digits[dig_sel[DIG_IDX_W-1:0]]);
      end else begin
         char_in = CH_SPACE;
      end
      last_in = (pos_ff == total_ff - FIELD_W'(1));
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (chain_done) begin
               state_in = ST_LAYOUT;
            end
         end
         ST_LAYOUT: begin
            pos_in = '0;
            if (total == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               pos_in = pos_ff + FIELD_W'(1);
               if (last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // output register
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   // checks
   `UDFF_NEVER(a_pos_past_field, clock, reset, (state_ff == ST_EMIT) && (pos_ff >= total_ff))
   `UDFF_ASSERT(a_digits_bcd, clock, reset, (state_ff == ST_LAYOUT) |-> digits_ok)
   `UDFF_ASSERT(a_beat_starts_convert, clock, reset, accept |=> (state_ff == ST_CONVERT))
   `UDFF_ASSERT(a_last_ends_field, clock, reset, (out_load && last_in) |=> (state_ff == ST_IDLE))

endmodule

// ===== design/udff_bcd_cell.sv =====
// ---------------------------------------------------------------------------
// udff_bcd_cell
// one decimal digit of the shift-and-add-3 binary to bcd converter
// ---------------------------------------------------------------------------
module udff_bcd_cell
   import udff_pkg::*;
(
   input  logic             clock,
   input  logic             clear,
   input  logic             shift,
   input  logic             bit_in,
   output logic [BCD_W-1:0] digit,
   output logic             carry_out
);

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in;
   logic [BCD_W-1:0] adj;

   // add three when the digit would overflow on doubling
   always_comb begin
      if (digit_ff >= BCD_W'(5)) begin
         adj = digit_ff + BCD_W'(3);
      end else begin
         adj = digit_ff;
      end
   end

   assign carry_out = adj[BCD_W-1];
   assign digit     = digit_ff;

   // next digit: cleared on load, doubled plus incoming bit on shift
   always_comb begin
      if (clear) begin
         digit_in = '0;
      end else if (shift) begin
         digit_in = {adj[BCD_W-2:0], bit_in};
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// ===== design/udff_digit_chain.sv =====
// ---------------------------------------------------------------------------
// udff_digit_chain
// value shift register feeding a row of bcd cells, one bit per cycle
// ---------------------------------------------------------------------------
module udff_digit_chain
   import udff_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  chain_ctrl_type     ctrl,
   input  logic [VALUE_W-1:0] value,
   output bcd_row_type        digits,
   output logic               done
);

   logic [VALUE_W-1:0]    value_ff;
   logic [VALUE_W-1:0]    value_in;
   logic [CNT_W-1:0]      bit_cnt_ff;
   logic [CNT_W-1:0]      bit_cnt_in;
   logic [NUM_DIGITS-1:0] cell_bit_in;
   logic [NUM_DIGITS-1:0] cell_carry;

   // value register, msb first into the chain
   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = value;
      end else if (ctrl.shift) begin
         value_in = {value_ff[VALUE_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // bit counter
   always_comb begin
      bit_cnt_in = bit_cnt_ff;
      if (ctrl.load) begin
         bit_cnt_in = '0;
      end else if (ctrl.shift) begin
         bit_cnt_in = bit_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= '0;
      end else begin
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   assign done = ctrl.shift && (bit_cnt_ff == CNT_W'(VALUE_W - 1));

   // carry of each cell feeds its upper neighbour
   assign cell_bit_in = {cell_carry[NUM_DIGITS-2:0], value_ff[VALUE_W-1]};

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      udff_bcd_cell u_cell (
         .clock     (clock),
         .clear     (ctrl.load),
         .shift     (ctrl.shift),
         .bit_in    (cell_bit_in[i]),
         .digit     (digits[i]),
         .carry_out (cell_carry[i])
      );
   end

endmodule
